>>> rtl/ejtag_processor_access_responder_top_assert.svh
// Assertion macros for the EJTAG processor access responder.
`ifndef EJTAG_PROCESSOR_ACCESS_RESPONDER_TOP_ASSERT_SVH
`define EJTAG_PROCESSOR_ACCESS_RESPONDER_TOP_ASSERT_SVH

// same-cycle implication
`define EJA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EJA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/eja_pkg.sv
// Types, constants and lane mask table for the EJTAG processor access responder.
package eja_pkg;

  localparam logic [31:0] CLEAN_CLEAR  = 32'h9FB3_3FF7;
  localparam logic [31:0] RESP_CLEAR   = 32'h9FB7_3FF7;
  localparam logic [31:0] FORCED_BITS  = 32'h0000_C000;
  localparam logic [31:0] PENDING_BIT  = 32'h0004_0000;
  localparam logic [10:0] WINDOW_TAG   = 11'h7F9;

  localparam logic [1:0] ACC_READ  = 2'b01;
  localparam logic [1:0] ACC_WRITE = 2'b11;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_LITTLE_ENDIAN  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_PRESENT = 8'd1;

  typedef struct packed {
    logic [31:0] control_word;
    logic [31:0] captured_data;
    logic [31:0] access_address;
  } in_word_t;

  typedef struct packed {
    logic        served;
    logic [31:0] response_control;
    logic [31:0] response_data;
    logic [31:0] next_poll_control;
    logic        bad_byte_select;
  } out_word_t;

  typedef struct packed {
    logic little_endian;
    logic memory_present;
  } cfg_t;

  typedef struct packed {
    logic        en;
    logic [31:0] data;
  } mem_wr_t;

  // entry [k] is the mask for address low bits k
  localparam logic [3:0][31:0] BE_BYTE   = {32'h0000_00FF, 32'h0000_FF00,
                                            32'h00FF_0000, 32'hFF00_0000};
  localparam logic [3:0][31:0] BE_HALF   = {32'h0, 32'h0000_FFFF, 32'h0, 32'hFFFF_0000};
  localparam logic [3:0][31:0] BE_TRIPLE = {32'h0, 32'h0, 32'h00FF_FFFF, 32'hFFFF_FF00};
  localparam logic [3:0][31:0] LE_BYTE   = {32'hFF00_0000, 32'h00FF_0000,
                                            32'h0000_FF00, 32'h0000_00FF};
  localparam logic [3:0][31:0] LE_HALF   = {32'h0, 32'hFFFF_0000, 32'h0, 32'h0000_FFFF};
  localparam logic [3:0][31:0] LE_TRIPLE = {32'h0, 32'h0, 32'hFFFF_FF00, 32'h00FF_FFFF};
  localparam logic [3:0][31:0] ANY_WORD  = {32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};

  function automatic logic [31:0] lane_mask(input logic le, input logic [1:0] psz,
                                            input logic [1:0] lo);
    logic [31:0] m;
    unique case (psz)
      2'd0:    m = le ? LE_BYTE[lo]   : BE_BYTE[lo];
      2'd1:    m = le ? LE_HALF[lo]   : BE_HALF[lo];
      2'd2:    m = ANY_WORD[lo];
      default: m = le ? LE_TRIPLE[lo] : BE_TRIPLE[lo];
    endcase
    return m;
  endfunction

endpackage

>>> rtl/ejtag_processor_access_responder_top.sv
// Flow: an accepted word is registered with its debug memory read, then merged,
// written back on a hit and posted to out_data once the output register is free;
// the block takes no new poll word until that read-modify-write has finished.
// A finished result waits in the output register while the next word is taken.
// Reset: synchronous; clears the sequencer, output valid and config registers
// (little_endian 0, memory_present 1); memory contents are not cleared.
module ejtag_processor_access_responder_top #(
  parameter int MEM_WORDS = 524288
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  eja_pkg::in_word_t                in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output eja_pkg::out_word_t               out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [eja_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                      cfg_data
);
  import eja_pkg::*;

`include "ejtag_processor_access_responder_top_assert.svh"

  localparam int IDX_W = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RMW  = 1'b1;

  logic        state;
  logic        state_next;
  in_word_t    item;
  logic [31:0] rd_data;
  cfg_t        cfg;
  out_word_t   result;
  mem_wr_t     wr;
  logic        advance;
  logic        accept;

  logic [31:0] mem [MEM_WORDS];

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign advance   = (state == S_RMW) && (!out_valid || out_ready);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_RMW;
      default: if (advance) state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      cfg       <= '{little_endian: 1'b0, memory_present: 1'b1};
    end else begin
      state <= state_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LITTLE_ENDIAN: begin
            cfg.little_endian <= cfg_data[0];
          end
          CFG_MEMORY_PRESENT: begin
            cfg.memory_present <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (advance) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= mem[in_data.access_address[IDX_W+1:2]];
    end
    if (advance && wr.en) begin
      mem[item.access_address[IDX_W+1:2]] <= wr.data;
    end
  end

  eja_resp #(
    .MEM_WORDS(MEM_WORDS)
  ) u_resp (
    .item   (item),
    .rd_data(rd_data),
    .cfg    (cfg),
    .result (result),
    .wr     (wr)
  );

  `EJA_ASSERT_NEXT(a_accept_to_rmw, accept, state == S_RMW, "accept did not start rmw")
  `EJA_ASSERT_NEXT(a_advance_out, advance, out_valid && state == S_IDLE, "result not posted")
  `EJA_ASSERT_NOW(a_bad_served, out_valid && out_data.bad_byte_select, out_data.served,
                  "bad byte select without served access")
  `EJA_ASSERT_NOW(a_served_poll, out_valid && out_data.served,
                  out_data.next_poll_control == '0, "next poll word set on served access")

endmodule

>>> rtl/eja_resp.sv
// Access decode, lane merge and response word build for one poll scan.
module eja_resp #(
  parameter int MEM_WORDS = 524288
) (
  input  eja_pkg::in_word_t  item,
  input  logic [31:0]        rd_data,
  input  eja_pkg::cfg_t      cfg,
  output eja_pkg::out_word_t result,
  output eja_pkg::mem_wr_t   wr
);
  import eja_pkg::*;

  localparam logic [19:0] MEM_LIMIT = 20'(MEM_WORDS);

  logic [31:0] ecr;
  logic [1:0]  acc;
  logic        hit;
  logic [31:0] mask;
  logic        is_rd;
  logic        is_wr;

  always_comb begin
    ecr   = (item.control_word & ~CLEAN_CLEAR) | FORCED_BITS;
    acc   = ecr[19:18];
    is_rd = (acc == ACC_READ);
    is_wr = (acc == ACC_WRITE);
    hit   = cfg.memory_present && (item.access_address[31:21] == WINDOW_TAG) &&
            ({1'b0, item.access_address[20:2]} < MEM_LIMIT);
    mask  = lane_mask(cfg.little_endian, ecr[30:29], item.access_address[1:0]);

    wr.en   = is_wr && hit;
    wr.data = (rd_data & ~mask) | (item.captured_data & mask);

    result.served            = is_rd || is_wr;
    result.response_control  = (is_rd || is_wr) ? ((ecr & ~RESP_CLEAR) | FORCED_BITS) : '0;
    result.response_data     = is_wr ? item.captured_data : ((is_rd && hit) ? rd_data : '0);
    result.next_poll_control = (is_rd || is_wr) ? '0 : (ecr | PENDING_BIT);
    result.bad_byte_select   = is_wr && hit && (mask == '0);
  end

endmodule
